[design/pfe_pkg.sv]
`default_nettype none
package pfe_pkg;

  localparam int SIDE    = 5;
  localparam int CELLS   = 25;
  localparam int LETTERS = 26;

  localparam logic [4:0] LET_I     = 5'd8;
  localparam logic [4:0] LET_J     = 5'd9;
  localparam logic [4:0] LET_Z     = 5'd25;
  localparam logic [4:0] PAD_RESET = 5'd23;

  typedef enum logic [2:0] {
    K_CLEAR  = 3'd0,
    K_KEY    = 3'd1,
    K_FINISH = 3'd2,
    K_TEXT   = 3'd3,
    K_END    = 3'd4
  } pfe_kind_t;

  // square / position memory commands
  typedef struct packed {
    logic       clear;
    logic       place;
    logic [4:0] letter;
  } pfe_sq_cmd_t;

  typedef struct packed {
    logic       pos_en;
    logic [4:0] pos_addr;
    logic       sq_en;
    logic [4:0] sq_addr;
  } pfe_sq_rd_t;

  function automatic logic [4:0] fold_j(logic [4:0] v);
    return (v == LET_J) ? LET_I : v;
  endfunction

  // row of a square position 0..24
  function automatic logic [2:0] pos_row(logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'(4 * SIDE))      r = 3'd4;
    else if (p >= 5'(3 * SIDE)) r = 3'd3;
    else if (p >= 5'(2 * SIDE)) r = 3'd2;
    else if (p >= 5'(SIDE))     r = 3'd1;
    else                        r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] pos_col(logic [4:0] p, logic [2:0] r);
    logic [4:0] base;
    base = {2'b00, r} * 5'(SIDE);
    return 3'(p - base);
  endfunction

  function automatic logic [2:0] wrap_inc(logic [2:0] v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] rc_addr(logic [2:0] r, logic [2:0] c);
    return {2'b00, r} * 5'(SIDE) + {2'b00, c};
  endfunction

endpackage
`default_nettype wire

[design/pfe_square.sv]
`default_nettype none
module pfe_square
  import pfe_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  pfe_sq_cmd_t cmd,
  input  pfe_sq_rd_t  rd,
  output logic [4:0]  pos_rd_data,
  output logic [4:0]  sq_rd_data,
  output logic        full
);

  logic [4:0]         sq_mem  [CELLS];
  logic [4:0]         pos_mem [LETTERS];
  logic [LETTERS-1:0] letter_used;
  logic [4:0]         fill_count;
  logic               do_place;

  assign full = (fill_count == 5'(CELLS));

  assign do_place = cmd.place && (cmd.letter < 5'(LETTERS)) && !full
                    && !letter_used[cmd.letter];

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_used <= '0;
      fill_count  <= '0;
    end else if (cmd.clear) begin
      letter_used <= '0;
      fill_count  <= '0;
    end else if (do_place) begin
      letter_used[cmd.letter] <= 1'b1;
      fill_count              <= fill_count + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_place && !cmd.clear) begin
      sq_mem[fill_count]  <= cmd.letter;
      pos_mem[cmd.letter] <= fill_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.pos_en) begin
      pos_rd_data <= pos_mem[rd.pos_addr];
    end
    if (rd.sq_en) begin
      sq_rd_data <= sq_mem[rd.sq_addr];
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= 5'(CELLS))
    else $error("fill count past square size");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !cmd.clear && !do_place |=> $stable(fill_count))
    else $error("fill count moved without a place");

  a_used_count: assert property (@(posedge clk) disable iff (rst)
    $countones(letter_used) == int'(fill_count))
    else $error("used letters disagree with fill count");

endmodule
`default_nettype wire

[design/pfe_pair_addr.sv]
`default_nettype none
module pfe_pair_addr
  import pfe_pkg::*;
(
  input  wire  [4:0] pos_a,
  input  wire  [4:0] pos_b,
  output logic [4:0] addr_x,
  output logic [4:0] addr_y
);

  logic [2:0] r1, c1, r2, c2;

  always_comb begin
    r1 = pos_row(pos_a);
    c1 = pos_col(pos_a, r1);
    r2 = pos_row(pos_b);
    c2 = pos_col(pos_b, r2);
    if (r1 == r2) begin
      addr_x = rc_addr(r1, wrap_inc(c1));
      addr_y = rc_addr(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      addr_x = rc_addr(wrap_inc(r1), c1);
      addr_y = rc_addr(wrap_inc(r2), c2);
    end else begin
      addr_x = rc_addr(r1, c2);
      addr_y = rc_addr(r2, c1);
    end
  end

endmodule
`default_nettype wire

[design/playfair_digraph_encrypt_top.sv]
`default_nettype none
// channel   | dir | signals                        | contents
// s_axis    | in  | tvalid tready tdata[7:0] tuser | tdata: letter[4:0]; tuser: kind[2:0]
// m_axis    | out | tvalid tready tdata[7:0] tlast | tdata: cipher_letter[4:0]; tlast: last_of_pair
// cfg       | in  | cfg_we cfg_wdata[4:0]          | pad_letter
//
// Clear, key letter, and a plaintext letter that gives no pair: taken in S_IDLE.
// Finish: one alphabet letter per cycle into the square, J and used letters skipped.
// A pair: S_LOOKA, S_LOOKB, S_CALC and S_RDX through the single read ports of the
// position and square memories, then two output beats, each held until m_axis_tready.
// Reset clears control and sets the pad to X; memories are not cleared,
// the fill count gates every read. s_axis_tready is low while busy.
module playfair_digraph_encrypt_top
  import pfe_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // letter[4:0], zero fill
  input  wire  [2:0] s_axis_tuser,   // kind[2:0]
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // cipher_letter[4:0], zero fill
  output logic       m_axis_tlast,
  input  wire        cfg_we,
  input  wire  [4:0] cfg_wdata
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FILL  = 8'b0000_0010,
    S_LOOKA = 8'b0000_0100,
    S_LOOKB = 8'b0000_1000,
    S_CALC  = 8'b0001_0000,
    S_RDX   = 8'b0010_0000,
    S_SENDX = 8'b0100_0000,
    S_SENDY = 8'b1000_0000
  } state_t;

  state_t      state;
  logic [4:0]  pad_letter;
  logic        pend_valid;
  logic [4:0]  pend_letter;
  logic [4:0]  a_letter, b_letter;
  logic [4:0]  pos_a;
  logic [4:0]  addr_y;
  logic [4:0]  fill_k;
  logic [4:0]  cipher;
  logic        last_q;

  logic        acc;
  logic [4:0]  in_letter;
  logic        let_ok;
  logic [4:0]  let_f;
  logic [4:0]  pad_v;
  pfe_kind_t   kind;
  pfe_sq_cmd_t cmd;
  pfe_sq_rd_t  rd;
  logic [4:0]  pos_rd_data, sq_rd_data;
  logic        full;
  logic [4:0]  calc_x, calc_y;

  assign s_axis_tready = (state == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign in_letter     = s_axis_tdata[4:0];
  assign kind          = pfe_kind_t'(s_axis_tuser);
  assign let_ok        = (in_letter < 5'(LETTERS));
  assign let_f         = fold_j(in_letter);
  assign pad_v         = fold_j((pad_letter > LET_Z) ? LET_Z : pad_letter);

  assign m_axis_tdata  = {3'b000, cipher};
  assign m_axis_tlast  = last_q;

  always_comb begin
    cmd.clear  = acc && (kind == K_CLEAR);
    cmd.place  = (acc && (kind == K_KEY) && let_ok) ||
                 ((state == S_FILL) && (fill_k != LET_J));
    cmd.letter = (state == S_FILL) ? fill_k : let_f;
    rd.pos_en   = (state == S_LOOKA) || (state == S_LOOKB);
    rd.pos_addr = (state == S_LOOKA) ? a_letter : b_letter;
    rd.sq_en    = (state == S_CALC) || (state == S_RDX);
    rd.sq_addr  = (state == S_CALC) ? calc_x : addr_y;
  end

  pfe_square u_square (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd          (rd),
    .pos_rd_data (pos_rd_data),
    .sq_rd_data  (sq_rd_data),
    .full        (full)
  );

  pfe_pair_addr u_pair_addr (
    .pos_a  (pos_a),
    .pos_b  (pos_rd_data),
    .addr_x (calc_x),
    .addr_y (calc_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pad_letter    <= PAD_RESET;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        pad_letter <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            case (kind)
              K_CLEAR: pend_valid <= 1'b0;
              K_FINISH: begin
                fill_k <= '0;
                state  <= S_FILL;
              end
              K_TEXT: begin
                if (let_ok) begin
                  if (!full) begin
                    pend_valid <= 1'b0;
                  end else if (!pend_valid) begin
                    pend_valid  <= 1'b1;
                    pend_letter <= let_f;
                  end else begin
                    a_letter <= pend_letter;
                    state    <= S_LOOKA;
                    if (let_f == pend_letter) begin
                      b_letter <= pad_v;
                    end else begin
                      b_letter   <= let_f;
                      pend_valid <= 1'b0;
                    end
                  end
                end
              end
              K_END: begin
                if (pend_valid) begin
                  pend_valid <= 1'b0;
                  if (full) begin
                    a_letter <= pend_letter;
                    b_letter <= pad_v;
                    state    <= S_LOOKA;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_FILL: begin
          fill_k <= fill_k + 5'd1;
          if (fill_k == 5'(LETTERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_LOOKA: state <= S_LOOKB;
        S_LOOKB: begin
          pos_a <= pos_rd_data;
          state <= S_CALC;
        end
        S_CALC: begin
          addr_y <= calc_y;
          state  <= S_RDX;
        end
        S_RDX: begin
          cipher        <= sq_rd_data;
          last_q        <= 1'b0;
          m_axis_tvalid <= 1'b1;
          state         <= S_SENDX;
        end
        S_SENDX: begin
          if (m_axis_tready) begin
            cipher <= sq_rd_data;
            last_q <= 1'b1;
            state  <= S_SENDY;
          end
        end
        S_SENDY: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while a beat is pending");

  a_pair_needs_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOKA) |-> full)
    else $error("pair lookup on an incomplete square");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !m_axis_tlast)
    else $error("pair opened on its second letter");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("second letter of pair missing");

endmodule
`default_nettype wire
